[hw/rtl/sha1_like_char_hash_top_assert.svh]
// Assertion macros shared by the hash block.
// Every check uses clk and is held off while rst_n is low.
`ifndef SHA1_LIKE_CHAR_HASH_TOP_ASSERT_SVH
`define SHA1_LIKE_CHAR_HASH_TOP_ASSERT_SVH

// Same-cycle implication.
`define SLCH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLCH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/slch_pkg.sv]
package slch_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int CHUNK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int CNT_W       = $clog2(CHUNK_WORDS);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int NUM_CHAIN   = 5;
    localparam int QUEUE_DEPTH = 2;

    // Round group boundaries
    localparam int RND_G1 = 20;
    localparam int RND_G2 = 40;
    localparam int RND_G3 = 60;

    // Initial chaining values
    localparam logic [WORD_W-1:0] IV0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] IV1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] IV3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] IV4 = 32'hC3D2_E1F0;

    // Round constants
    localparam logic [WORD_W-1:0] RK0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] RK1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] RK2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] RK3 = 32'hCA62_C1D6;

    typedef logic [WORD_W-1:0] word_t;

    // One unit of work for the compression engine
    typedef struct packed {
        logic [CHUNK_WORDS-1:0][WORD_W-1:0] words;
        logic                               compress;
        logic                               last;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_SUM
    } back_state_t;

    function automatic word_t iv_word(input int idx);
        word_t v;
        begin
            unique case (idx)
                0:       v = IV0;
                1:       v = IV1;
                2:       v = IV2;
                3:       v = IV3;
                default: v = IV4;
            endcase
            return v;
        end
    endfunction

    function automatic word_t rotl1(input word_t x);
        return {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[WORD_W-1:2]};
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] r);
        word_t k;
        begin
            priority if (r < ROUND_W'(RND_G1)) k = RK0;
            else if (r < ROUND_W'(RND_G2))     k = RK1;
            else if (r < ROUND_W'(RND_G3))     k = RK2;
            else                               k = RK3;
            return k;
        end
    endfunction

    function automatic word_t round_f(input logic [ROUND_W-1:0] r,
                                      input word_t b, input word_t c, input word_t d);
        word_t f;
        begin
            priority if (r < ROUND_W'(RND_G1)) f = (b & c) | (~b & d);
            else if (r < ROUND_W'(RND_G2))     f = b ^ c ^ d;
            else if (r < ROUND_W'(RND_G3))     f = (b & c) | (b & d) | (c & d);
            else                               f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

[hw/rtl/sha1_like_char_hash_top.sv]
// Channel   Ports                              Handshake
// input     char_byte, has_char, last          push / full
// result    hash_value                         pop / empty
//
// A 16-character chunk occupies the compression engine for a start step, 80 rounds
// and a fold; the round unit sets the pace.
// Collection of the next chunk overlaps compression through a job queue.
// A result is registered by the sum state after the final fold or an empty end job.
// rst_n clears control state asynchronously and loads the initial chain.
// full rises only when the job queue is full; a waiting result stalls the sum state.
module sha1_like_char_hash_top
    import slch_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_byte,
    input  logic              has_char,
    input  logic              last,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] hash_value
);

    job_t q_wr_data, q_rd_data;
    logic q_wr_en, q_full, q_valid, q_rd_en;

    slch_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .char_byte (char_byte),
        .has_char  (has_char),
        .last      (last),
        .q_full    (q_full),
        .full      (full),
        .q_push    (q_wr_en),
        .q_data    (q_wr_data)
    );

    slch_queue #(.DEPTH(QDEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .wr_data  (q_wr_data),
        .q_full   (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data)
    );

    slch_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job        (q_rd_data),
        .job_pop    (q_rd_en),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

endmodule

[hw/rtl/slch_front.sv]
module slch_front
    import slch_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [CHAR_W-1:0]   char_byte,
    input  logic                has_char,
    input  logic                last,
    input  logic                q_full,
    output logic                full,
    output logic                q_push,
    output job_t                q_data
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             buf_reg [CHUNK_WORDS];
    word_t             char_word;
    logic              accept;
    logic              chunk_done;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign char_word  = {{(WORD_W-CHAR_W){char_byte[CHAR_W-1]}}, char_byte};
    assign chunk_done = has_char && (cnt_reg == CNT_W'(CHUNK_WORDS-1));

    // Job words: held words, the new character, zero padding above
    always_comb
    begin
        for (int i = 0; i < CHUNK_WORDS; i++)
        begin
            if (CNT_W'(i) < cnt_reg)
                q_data.words[i] = buf_reg[i];
            else if (CNT_W'(i) == cnt_reg && has_char)
                q_data.words[i] = char_word;
            else
                q_data.words[i] = '0;
        end
        q_data.compress = chunk_done || has_char || (cnt_reg != '0);
        q_data.last     = last;
    end

    // Classify the beat: full chunk, message end, plain character or idle beat
    always_comb
    begin
        q_push   = 1'b0;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (chunk_done || last)
            begin
                q_push   = 1'b1;
                cnt_next = '0;
            end
            else if (has_char)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Character buffer
    always_ff @(posedge clk)
    begin
        if (accept && has_char)
            buf_reg[cnt_reg] <= char_word;
    end

endmodule

[hw/rtl/slch_queue.sv]
module slch_queue
    import slch_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic q_full,
    output logic rd_valid,
    input  logic rd_en,
    output job_t rd_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    job_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_wr, do_rd;

    assign q_full   = (count_reg == COUNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + COUNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - COUNT_W'(1);
        end
    end

endmodule

[hw/rtl/slch_back.sv]
`include "sha1_like_char_hash_top_assert.svh"

module slch_back
    import slch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        empty,
    input  logic        pop,
    output word_t       hash_value
);

    back_state_t          state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    word_t                vars_reg  [NUM_CHAIN];
    word_t                vars_next [NUM_CHAIN];
    word_t                chain_reg [NUM_CHAIN];
    word_t                chain_next[NUM_CHAIN];
    word_t                w_reg     [CHUNK_WORDS];
    word_t                w_next    [CHUNK_WORDS];
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    word_t                out_hash_reg, out_hash_next;
    word_t                temp;
    word_t                sched;

    assign empty      = !out_valid_reg;
    assign hash_value = out_hash_reg;

    // Round datapath and next schedule word
    assign temp  = rotl5(vars_reg[0]) + round_f(round_reg, vars_reg[1], vars_reg[2], vars_reg[3])
                 + vars_reg[4] + round_k(round_reg) + w_reg[0];
    assign sched = rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);

    // Engine sequencer
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        vars_next      = vars_reg;
        chain_next     = chain_reg;
        w_next         = w_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        job_pop        = 1'b0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    last_next = job.last;
                    if (job.compress)
                    begin
                        for (int i = 0; i < CHUNK_WORDS; i++)
                            w_next[i] = job.words[i];
                        vars_next  = chain_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_ROUND:
            begin
                vars_next[4] = vars_reg[3];
                vars_next[3] = vars_reg[2];
                vars_next[2] = rotl30(vars_reg[1]);
                vars_next[1] = vars_reg[0];
                vars_next[0] = temp;
                for (int i = 0; i < CHUNK_WORDS-1; i++)
                    w_next[i] = w_reg[i+1];
                w_next[CHUNK_WORDS-1] = sched;
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_W'(ROUNDS-1))
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < NUM_CHAIN; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                state_next = last_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = chain_reg[0] + chain_reg[1] + chain_reg[2]
                                   + chain_reg[3] + chain_reg[4];
                    for (int i = 0; i < NUM_CHAIN; i++)
                        chain_next[i] = iv_word(i);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and chaining values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHAIN; i++)
                chain_reg[i] <= iv_word(i);
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    // Working variables, schedule window, result word
    always_ff @(posedge clk)
    begin
        vars_reg     <= vars_next;
        w_reg        <= w_next;
        out_hash_reg <= out_hash_next;
    end

    `SLCH_ASSERT_NOW(a_round_range, state_reg == ST_ROUND, round_reg < ROUND_W'(ROUNDS), "round counter out of range")
    `SLCH_ASSERT_NEXT(a_round_end, state_reg == ST_ROUND && round_reg == ROUND_W'(ROUNDS-1), state_reg == ST_FOLD, "no fold after final round")
    `SLCH_ASSERT_NOW(a_pop_idle, job_pop, state_reg == ST_IDLE && job_valid, "job taken outside idle")
    `SLCH_ASSERT_NEXT(a_sum_wait, state_reg == ST_SUM && out_valid_reg && !pop, state_reg == ST_SUM, "sum lost while result waits")
    `SLCH_ASSERT_NEXT(a_iv_reload, state_reg == ST_SUM && (!out_valid_reg || pop), chain_reg[0] == IV0 && chain_reg[4] == IV4, "chain not reloaded after result")

endmodule

[dv/sha1_like_char_hash_top_test.sv]
module sha1_like_char_hash_top_test;
    import slch_pkg::*;

    localparam int TARGET_CHARS  = 480;
    localparam int MIN_MESSAGES  = 32;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 400000;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    logic [CHAR_W-1:0] char_byte = '0;
    logic              has_char  = 1'b0;
    logic              last      = 1'b0;
    logic              empty;
    logic              pop       = 1'b0;
    logic [WORD_W-1:0] hash_value;

    // Tracks the running chain per message and holds the digests still owed by the block
    class digest_tracker;
        word_t       chain[NUM_CHAIN];
        word_t       chunk_buf[CHUNK_WORDS];
        int unsigned fill;
        word_t       expected_digests[$];
        int unsigned mismatches;

        function new();
            load_chain();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void load_chain();
            chain[0] = IV0;
            chain[1] = IV1;
            chain[2] = IV2;
            chain[3] = IV3;
            chain[4] = IV4;
        endfunction

        static function word_t rot(word_t x, int unsigned n);
            return (x << n) | (x >> (WORD_W - n));
        endfunction

        // 80-round compression of the buffered chunk into the chain
        function void fold_chunk();
            word_t sched[ROUNDS];
            word_t a, b, c, d, e, f, k, t;
            for (int i = 0; i < CHUNK_WORDS; i++)
                sched[i] = chunk_buf[i];
            for (int i = CHUNK_WORDS; i < ROUNDS; i++)
                sched[i] = rot(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int i = 0; i < ROUNDS; i++)
            begin
                if (i < RND_G1)
                begin
                    f = (b & c) | (~b & d);
                    k = RK0;
                end
                else if (i < RND_G2)
                begin
                    f = b ^ c ^ d;
                    k = RK1;
                end
                else if (i < RND_G3)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = RK2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = RK3;
                end
                t = rot(a, 5) + f + e + k + sched[i];
                e = d;
                d = c;
                c = rot(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Accepted input beat: character first, then message end
        function void note_beat(logic [CHAR_W-1:0] ch, logic has, logic fin);
            word_t sum;
            if (has)
            begin
                chunk_buf[fill] = {{(WORD_W-CHAR_W){ch[CHAR_W-1]}}, ch};
                fill++;
                if (fill == CHUNK_WORDS)
                begin
                    fold_chunk();
                    fill = 0;
                end
            end
            if (fin)
            begin
                if (fill != 0)
                begin
                    for (int i = fill; i < CHUNK_WORDS; i++)
                        chunk_buf[i] = '0;
                    fold_chunk();
                end
                sum = chain[0] + chain[1] + chain[2] + chain[3] + chain[4];
                expected_digests.push_back(sum);
                load_chain();
                fill = 0;
            end
        endfunction

        // Accepted result beat against the oldest owed digest
        function void check_digest(word_t got);
            word_t want;
            if (expected_digests.size() == 0)
            begin
                $error("hash_value: no result expected, actual %h", got);
                mismatches++;
            end
            else
            begin
                want = expected_digests.pop_front();
                if (got !== want)
                begin
                    $error("hash_value: expected %h, actual %h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    digest_tracker tracker = new();

    int unsigned burst_left;
    int unsigned chars_sent;
    int unsigned messages_sent;
    int unsigned cycle_count = 0;
    int unsigned stall_cycle = 0;
    int unsigned stall_mode  = 0;
    logic [31:0] stall_mask  = '1;

    sha1_like_char_hash_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_byte  (char_byte),
        .has_char   (has_char),
        .last       (last),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: check popped beats, then pick pop for the next edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_digest(hash_value);
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 64 == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_mask <= $urandom;
        end
        case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= stall_mask[stall_cycle % 32];
            default: pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // One input beat; bursts of random length with random gaps between them
    task automatic send_beat(logic [CHAR_W-1:0] ch, logic has, logic fin);
        push      <= 1'b1;
        char_byte <= ch;
        has_char  <= has;
        last      <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_beat(ch, has, fin);
        if (has)
            chars_sent++;
        if (fin)
            messages_sent++;
        if (burst_left <= 1)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        else
            burst_left--;
    endtask

    // Random message; ends on the final character or on a separate end beat
    task automatic send_message(int unsigned len, bit separate_end);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_beat(CHAR_W'($urandom), 1'b0, 1'b0);
            send_beat(CHAR_W'($urandom), 1'b1, (i == len - 1) && !separate_end);
        end
        if (len == 0 || separate_end)
            send_beat(CHAR_W'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int unsigned len;
        int unsigned pick;

        burst_left    = 4;
        chars_sent    = 0;
        messages_sent = 0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, idle beat, short message, single extreme char
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b1);
        send_beat(8'h80, 1'b1, 1'b1);

        // Directed: chunk filled exactly by the final character
        for (int i = 0; i < CHUNK_WORDS; i++)
        begin
            case (i)
                0:       pick = 8'h80;
                1:       pick = 8'h00;
                2:       pick = 8'h7F;
                3:       pick = 8'hFF;
                default: pick = $urandom;
            endcase
            send_beat(CHAR_W'(pick), 1'b1, i == CHUNK_WORDS - 1);
        end

        // Random messages, mostly short, some around chunk boundaries
        while (chars_sent < TARGET_CHARS || messages_sent < MIN_MESSAGES)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len = $urandom_range(0, 2);
                7:       len = CHUNK_WORDS * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
                8:       len = $urandom_range(35, 64);
                default: len = $urandom_range(1, 20);
            endcase
            send_message(len, $urandom_range(0, 2) == 0);
        end
        if (push)
            push <= 1'b0;

        // Drain outstanding digests, then watch for strays
        while (tracker.expected_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.mismatches == 0 && tracker.expected_digests.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
